@@ rtl/tna_pkg.sv @@
// Shared types, constants and the seed inverse table for the 2-adic ALU.
package tna_pkg;

  localparam int WORD_W = 64;
  localparam int SIG_W = 45;
  localparam int EXP_W = WORD_W - SIG_W;
  localparam int PROD_W = 2 * SIG_W;
  localparam int LO_W = (SIG_W + 1) / 2;
  localparam int HI_W = SIG_W - LO_W;
  localparam int KS_W = $clog2(SIG_W);
  localparam int KP_W = $clog2(PROD_W);
  localparam int SH_W = $clog2(WORD_W);
  localparam int SEED_W = 8;
  localparam int CFG_ADDR_W = 4;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_NEG = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_CMP = 3'd5;

  localparam logic [1:0] ORD_LESS = 2'd0;
  localparam logic [1:0] ORD_EQUAL = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  localparam logic REG_DZ_NONNEG = 1'b0;
  localparam logic REG_DZ_NEG = 1'b1;

  localparam logic [WORD_W-1:0] DZ_NONNEG_RST = 64'h7FFF_EFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] DZ_NEG_RST = 64'h8000_1000_0000_0000;

  typedef struct packed {
    logic [2:0]        operation;
    logic [WORD_W-1:0] operand_a;
    logic [WORD_W-1:0] operand_b;
  } tna_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic [1:0]        order;
    logic              divide_by_zero;
  } tna_out_t;

  typedef logic [SEED_W-1:0] inv_tab_t [2**(SEED_W-1)];

  // Inverse of each odd byte modulo 256; the odd value 2i+1 sits at entry i.
  function automatic inv_tab_t gen_inv_tab();
    inv_tab_t t;
    logic [SEED_W-1:0] m;
    logic [SEED_W-1:0] x;
    for (int i = 0; i < 2**(SEED_W-1); i++) begin
      m = SEED_W'(2 * i + 1);
      x = m;
      repeat (3) x = SEED_W'(x * SEED_W'(SEED_W'(2) - SEED_W'(m * x)));
      t[i] = x;
    end
    return t;
  endfunction

  localparam inv_tab_t INV_SEED = gen_inv_tab();

endpackage

@@ rtl/tna_delay.sv @@
// Plain register delay line for payload that must stay aligned with the pipeline.
module tna_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [D];

  always_ff @(posedge clk) begin
    pipe_r[0] <= d;
    for (int i = 1; i < D; i++) begin
      pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign q = pipe_r[D-1];

endmodule

@@ rtl/tna_mul.sv @@
// Two-stage unsigned significand multiplier built from four half-width products.
module tna_mul (
  input  logic                        clk,
  input  logic [tna_pkg::SIG_W-1:0]   a,
  input  logic [tna_pkg::SIG_W-1:0]   b,
  output logic [tna_pkg::PROD_W-1:0]  p
);
  import tna_pkg::*;

  logic [2*LO_W-1:0]    ll_r;
  logic [LO_W+HI_W-1:0] lh_r;
  logic [LO_W+HI_W-1:0] hl_r;
  logic [2*HI_W-1:0]    hh_r;
  logic [PROD_W-1:0]    p_r;
  logic [PROD_W-1:0]    p_nxt;

  always_ff @(posedge clk) begin
    ll_r <= (2*LO_W)'(a[LO_W-1:0]) * (2*LO_W)'(b[LO_W-1:0]);
    lh_r <= (LO_W+HI_W)'(a[LO_W-1:0]) * (LO_W+HI_W)'(b[SIG_W-1:LO_W]);
    hl_r <= (LO_W+HI_W)'(a[SIG_W-1:LO_W]) * (LO_W+HI_W)'(b[LO_W-1:0]);
    hh_r <= (2*HI_W)'(a[SIG_W-1:LO_W]) * (2*HI_W)'(b[SIG_W-1:LO_W]);
    p_r  <= p_nxt;
  end

  always_comb begin
    p_nxt = PROD_W'(ll_r) + (PROD_W'(lh_r) << LO_W) + (PROD_W'(hl_r) << LO_W)
          + (PROD_W'(hh_r) << (2 * LO_W));
  end

  assign p = p_r;

endmodule

@@ rtl/tna_div.sv @@
// Hensel quotient: Newton inverse of the odd divisor, then times the dividend magnitude.
module tna_div (
  input  logic                        clk,
  input  logic [tna_pkg::SIG_W-1:0]   m_odd,
  input  logic [tna_pkg::SEED_W-1:0]  seed,
  input  logic [tna_pkg::SIG_W-1:0]   mag_a,
  output logic [tna_pkg::SIG_W-1:0]   quo
);
  import tna_pkg::*;

  localparam int ITER = 3;
  localparam int MUL_LAT = 2;

  logic [SIG_W-1:0]  m_s [ITER];
  logic [SIG_W-1:0]  x_s [ITER+1];
  logic [SIG_W-1:0]  mag_d;
  logic [PROD_W-1:0] q_full;

  assign m_s[0] = m_odd;
  assign x_s[0] = SIG_W'(seed);

  // Each step doubles the number of correct low bits: x' = x * (2 - m * x).
  for (genvar j = 0; j < ITER; j++) begin : g_iter
    logic [PROD_W-1:0] t_full;
    logic [PROD_W-1:0] x_full;
    logic [SIG_W-1:0]  x_d;
    logic [SIG_W-1:0]  corr;

    tna_mul u_mul_t (.clk(clk), .a(m_s[j]), .b(x_s[j]), .p(t_full));
    tna_delay #(.W(SIG_W), .D(MUL_LAT)) u_dly_x (.clk(clk), .d(x_s[j]), .q(x_d));
    assign corr = SIG_W'(2) - t_full[SIG_W-1:0];
    tna_mul u_mul_x (.clk(clk), .a(x_d), .b(corr), .p(x_full));
    assign x_s[j+1] = x_full[SIG_W-1:0];

    if (j < ITER - 1) begin : g_mdly
      tna_delay #(.W(SIG_W), .D(2 * MUL_LAT)) u_dly_m (
        .clk(clk), .d(m_s[j]), .q(m_s[j+1]));
    end
  end

  tna_delay #(.W(SIG_W), .D(2 * MUL_LAT * ITER)) u_dly_mag (
    .clk(clk), .d(mag_a), .q(mag_d));

  tna_mul u_mul_q (.clk(clk), .a(mag_d), .b(x_s[ITER]), .p(q_full));

  assign quo = q_full[SIG_W-1:0];

endmodule

@@ rtl/two_adic_number_alu.sv @@
// A word taken with start appears on out_word, with out_strobe high, for one cycle.
// Throughput: one word per cycle; busy is never raised and the receiver cannot stall.
// The depth is set by the divide path: seven chained two-stage multipliers that form
// the Newton inverse and the final product; other operations are padded to match.
// Reset clears the pipeline valid bits and loads the default zero-divisor words.
module two_adic_number_alu (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  tna_pkg::tna_in_t                in_word,
  output logic                            out_strobe,
  output tna_pkg::tna_out_t               out_word,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tna_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tna_pkg::WORD_W-1:0]      pwdata,
  output logic [tna_pkg::WORD_W-1:0]      prdata,
  output logic                            pready
);
  import tna_pkg::*;

  localparam int VLD_N = 16;

  typedef struct packed {
    logic [2:0]        op;
    logic [WORD_W-1:0] neg_word;
    logic [1:0]        order;
  } meta_t;

  typedef struct packed {
    logic             na;
    logic             sgn;
    logic             dz;
    logic [EXP_W-1:0] exp_div;
  } div_meta_t;

  function automatic logic [KS_W-1:0] tz_sig(input logic [SIG_W-1:0] v);
    logic [KS_W-1:0] k;
    k = KS_W'(SIG_W - 1);
    for (int i = SIG_W - 2; i >= 0; i--) begin
      if (v[i]) k = KS_W'(i);
    end
    return k;
  endfunction

  function automatic logic [KP_W-1:0] tz_prod(input logic [PROD_W-1:0] v);
    logic [KP_W-1:0] k;
    k = '0;
    for (int i = PROD_W - 1; i >= 0; i--) begin
      if (v[i]) k = KP_W'(i);
    end
    return k;
  endfunction

  // Configuration registers.
  logic [WORD_W-1:0] dz_nonneg_r;
  logic [WORD_W-1:0] dz_neg_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[SH_W-3] == REG_DZ_NEG) ? dz_neg_r : dz_nonneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_nonneg_r <= DZ_NONNEG_RST;
      dz_neg_r    <= DZ_NEG_RST;
    end else if (cfg_wr) begin
      if (paddr[SH_W-3] == REG_DZ_NEG) begin
        dz_neg_r <= pwdata;
      end else begin
        dz_nonneg_r <= pwdata;
      end
    end
  end

  assign busy = 1'b0;

  // Valid bits.
  logic [VLD_N-1:0] vld_r;
  logic [VLD_N-1:0] vld_nxt;
  logic             out_strobe_r;

  assign vld_nxt = {vld_r[VLD_N-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= vld_nxt;
      out_strobe_r <= vld_r[VLD_N-1];
    end
  end

  // Stage 1: decode.
  logic [SIG_W-1:0]  a_sig, b_sig, bs_eff, negb_sig;
  logic [WORD_W-1:0] sa_nxt, sb_nxt, sa_s1_r, sb_s1_r;
  logic [EXP_W-1:0]  ea_nxt, eb_nxt, ea_s1_r, eb_s1_r;
  logic [EXP_W:0]    diff_nxt, diff_s1_r;
  logic [SIG_W-1:0]  ma_nxt, mb_nxt, ma_s1_r, mb_s1_r;
  logic [KS_W-1:0]   kd_nxt, kd_s1_r;
  logic              na_nxt, nb_nxt, na_s1_r, sgn_s1_r, dz_nxt, dz_s1_r;
  meta_t             meta_nxt, meta_s1_r;
  logic [EXP_W-1:0]  esum_nxt, esum_s1_r;

  always_comb begin
    a_sig    = in_word.operand_a[SIG_W-1:0];
    b_sig    = in_word.operand_b[SIG_W-1:0];
    negb_sig = SIG_W'(-b_sig);
    bs_eff   = (in_word.operation == OP_SUB) ? negb_sig : b_sig;
    sa_nxt   = {{(WORD_W-SIG_W){a_sig[SIG_W-1]}}, a_sig};
    sb_nxt   = {{(WORD_W-SIG_W){bs_eff[SIG_W-1]}}, bs_eff};
    ea_nxt   = in_word.operand_a[WORD_W-1:SIG_W];
    eb_nxt   = in_word.operand_b[WORD_W-1:SIG_W];
    diff_nxt = {ea_nxt[EXP_W-1], ea_nxt} - {eb_nxt[EXP_W-1], eb_nxt};
    na_nxt   = a_sig[SIG_W-1];
    nb_nxt   = b_sig[SIG_W-1];
    ma_nxt   = na_nxt ? SIG_W'(-a_sig) : a_sig;
    mb_nxt   = nb_nxt ? negb_sig : b_sig;
    kd_nxt   = tz_sig(b_sig);
    dz_nxt   = (b_sig == '0);
    esum_nxt = ea_nxt + eb_nxt;
    meta_nxt.op       = in_word.operation;
    meta_nxt.neg_word = {eb_nxt, negb_sig};
    if (in_word.operand_a == in_word.operand_b) begin
      meta_nxt.order = ORD_EQUAL;
    end else if (ea_nxt > eb_nxt) begin
      meta_nxt.order = ORD_GREATER;
    end else if (ea_nxt < eb_nxt) begin
      meta_nxt.order = ORD_LESS;
    end else if (a_sig > b_sig) begin
      meta_nxt.order = ORD_GREATER;
    end else begin
      meta_nxt.order = ORD_LESS;
    end
  end

  always_ff @(posedge clk) begin
    sa_s1_r   <= sa_nxt;
    sb_s1_r   <= sb_nxt;
    ea_s1_r   <= ea_nxt;
    eb_s1_r   <= eb_nxt;
    diff_s1_r <= diff_nxt;
    ma_s1_r   <= ma_nxt;
    mb_s1_r   <= mb_nxt;
    kd_s1_r   <= kd_nxt;
    na_s1_r   <= na_nxt;
    sgn_s1_r  <= na_nxt ^ nb_nxt;
    dz_s1_r   <= dz_nxt;
    esum_s1_r <= esum_nxt;
    meta_s1_r <= meta_nxt;
  end

  // Add path: align, sum, count trailing zeros, normalise.
  logic [EXP_W:0]    dneg;
  logic [WORD_W-1:0] ax_nxt, ay_nxt, ax_s2_r, ay_s2_r;
  logic [EXP_W-1:0]  er_nxt, er_s2_r, er_s3_r, er_s4_r;
  logic [WORD_W-1:0] sum_s3_r, sum_s4_r, shifted;
  logic [KS_W-1:0]   ka_s4_r;
  logic              zero_s4_r;
  logic [WORD_W-1:0] addw_nxt, addw_s5_r, addw_d;

  always_comb begin
    dneg   = -diff_s1_r;
    ax_nxt = sa_s1_r;
    ay_nxt = sb_s1_r;
    er_nxt = ea_s1_r;
    if (!diff_s1_r[EXP_W] && (diff_s1_r != '0)) begin
      ax_nxt = (|diff_s1_r[EXP_W:SH_W]) ? '0 : (sa_s1_r << diff_s1_r[SH_W-1:0]);
      er_nxt = eb_s1_r;
    end else if (diff_s1_r[EXP_W]) begin
      ay_nxt = (|dneg[EXP_W:SH_W]) ? '0 : (sb_s1_r << dneg[SH_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    ax_s2_r   <= ax_nxt;
    ay_s2_r   <= ay_nxt;
    er_s2_r   <= er_nxt;
    sum_s3_r  <= ax_s2_r + ay_s2_r;
    er_s3_r   <= er_s2_r;
    sum_s4_r  <= sum_s3_r;
    er_s4_r   <= er_s3_r;
    ka_s4_r   <= tz_sig(sum_s3_r[SIG_W-1:0]);
    zero_s4_r <= (sum_s3_r == '0);
    addw_s5_r <= addw_nxt;
  end

  always_comb begin
    shifted  = WORD_W'($signed(sum_s4_r) >>> ka_s4_r);
    addw_nxt = zero_s4_r ? '0 : {EXP_W'(er_s4_r + EXP_W'(ka_s4_r)), shifted[SIG_W-1:0]};
  end

  tna_delay #(.W(WORD_W), .D(11)) u_dly_add (.clk(clk), .d(addw_s5_r), .q(addw_d));

  // Multiply path: exact product, strip trailing zeros, apply sign.
  logic [PROD_W-1:0] prod_s3, prod_s4_r;
  logic [KP_W-1:0]   kp_s4_r, kp_s5_r;
  logic [SIG_W-1:0]  mr_s5_r;
  logic [EXP_W:0]    mmeta_d;
  logic [PROD_W-1:0] prod_sh;
  logic [WORD_W-1:0] mulw_nxt, mulw_s6_r, mulw_d;
  logic [SIG_W-1:0]  mr_signed;

  tna_mul u_mul (.clk(clk), .a(ma_s1_r), .b(mb_s1_r), .p(prod_s3));

  tna_delay #(.W(EXP_W+1), .D(4)) u_dly_mmeta (
    .clk(clk), .d({sgn_s1_r, esum_s1_r}), .q(mmeta_d));

  assign prod_sh = prod_s4_r >> kp_s4_r;

  always_ff @(posedge clk) begin
    prod_s4_r <= prod_s3;
    kp_s4_r   <= tz_prod(prod_s3);
    mr_s5_r   <= prod_sh[SIG_W-1:0];
    kp_s5_r   <= kp_s4_r;
    mulw_s6_r <= mulw_nxt;
  end

  always_comb begin
    mr_signed = mmeta_d[EXP_W] ? SIG_W'(-mr_s5_r) : mr_s5_r;
    mulw_nxt  = {EXP_W'(mmeta_d[EXP_W-1:0] + EXP_W'(kp_s5_r)), mr_signed};
  end

  tna_delay #(.W(WORD_W), .D(10)) u_dly_mul (.clk(clk), .d(mulw_s6_r), .q(mulw_d));

  // Divide path: strip the divisor's trailing zeros and look up a seed inverse.
  logic [SIG_W-1:0] modd_nxt, modd_s2_r, ma_s2_r;
  logic [SEED_W-1:0] seed_s2_r;
  div_meta_t        dmeta_nxt, dmeta_s2_r, dmeta_d;
  logic [SIG_W-1:0] quo;

  always_comb begin
    modd_nxt          = mb_s1_r >> kd_s1_r;
    dmeta_nxt.na      = na_s1_r;
    dmeta_nxt.sgn     = sgn_s1_r;
    dmeta_nxt.dz      = dz_s1_r;
    dmeta_nxt.exp_div = ea_s1_r - eb_s1_r - EXP_W'(kd_s1_r);
  end

  always_ff @(posedge clk) begin
    modd_s2_r  <= modd_nxt;
    seed_s2_r  <= INV_SEED[modd_nxt[SEED_W-1:1]];
    ma_s2_r    <= ma_s1_r;
    dmeta_s2_r <= dmeta_nxt;
  end

  tna_div u_div (
    .clk  (clk),
    .m_odd(modd_s2_r),
    .seed (seed_s2_r),
    .mag_a(ma_s2_r),
    .quo  (quo)
  );

  tna_delay #(.W($bits(div_meta_t)), .D(14)) u_dly_dmeta (
    .clk(clk), .d(dmeta_s2_r), .q(dmeta_d));

  // Common metadata, and the final selection into the output register.
  meta_t    meta_d;
  tna_out_t out_word_nxt, out_word_r;

  tna_delay #(.W($bits(meta_t)), .D(15)) u_dly_meta (
    .clk(clk), .d(meta_s1_r), .q(meta_d));

  always_comb begin
    out_word_nxt.result_word    = '0;
    out_word_nxt.order          = ORD_EQUAL;
    out_word_nxt.divide_by_zero = 1'b0;
    case (meta_d.op)
      OP_ADD, OP_SUB: begin
        out_word_nxt.result_word = addw_d;
      end
      OP_NEG: begin
        out_word_nxt.result_word = meta_d.neg_word;
      end
      OP_MUL: begin
        out_word_nxt.result_word = mulw_d;
      end
      OP_DIV: begin
        if (dmeta_d.dz) begin
          out_word_nxt.result_word    = dmeta_d.na ? dz_neg_r : dz_nonneg_r;
          out_word_nxt.divide_by_zero = 1'b1;
        end else begin
          out_word_nxt.result_word = {dmeta_d.exp_div, dmeta_d.sgn ? SIG_W'(-quo) : quo};
        end
      end
      OP_CMP: begin
        out_word_nxt.order = meta_d.order;
      end
      default: begin
        out_word_nxt.result_word = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule
